// ===== rtl/core/sss_pkg.sv =====
// shared types and constants of the schrodinger stencil step block
package sss_pkg;

    // line buffer geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // configuration field widths
    localparam int GW_W      = 11;
    localparam int GH_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int FILL_W    = GW_W;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 2;

    // smallest usable grid side
    localparam int MIN_DIM   = 3;

    // reset values of the configuration registers
    localparam logic [GW_W-1:0]   GRID_WIDTH_RST  = GW_W'(1024);
    localparam logic [GH_W-1:0]   GRID_HEIGHT_RST = GH_W'(1024);
    localparam logic [GAIN_W-1:0] LAP_GAIN_RST    = GAIN_W'(328);
    localparam logic [GAIN_W-1:0] TIME_STEP_RST   = GAIN_W'(66);

    // data widths
    localparam int PSI_W  = 16;
    localparam int POT_W  = 16;
    localparam int LAP_W  = PSI_W + 3;
    localparam int GPR_W  = GAIN_W + 1 + LAP_W;
    localparam int TV_W   = GAIN_W + 1 + POT_W;
    localparam int TVC_W  = TV_W + PSI_W;
    localparam int ACC_W  = 52;
    localparam int FRAC_SH = 24;
    localparam int LAP_SH  = 8;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_LAP_GAIN    = 2'd2,
        REG_TIME_STEP   = 2'd3
    } t_reg_idx;

    // one complex cell as stored in the line buffer
    typedef struct packed {
        logic signed [PSI_W-1:0] im;
        logic signed [PSI_W-1:0] re;
    } t_cell;

    // one line buffer word: potential, center row cell, above row cell
    typedef struct packed {
        logic signed [POT_W-1:0] pot;
        t_cell                   center;
        t_cell                   above;
    } t_line;

    // per-request status carried down the pipeline
    typedef struct packed {
        logic valid;
        logic interior;
        logic last;
    } t_flags;

endpackage

// ===== rtl/core/sss_if.sv =====
// stream and configuration channels of the schrodinger stencil step block

// input cell channel
interface sss_cell_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sss_pkg::PSI_W-1:0]     psi_re;
    logic signed [sss_pkg::PSI_W-1:0]     psi_im;
    logic signed [sss_pkg::POT_W-1:0]     potential;

    modport source (output valid, psi_re, psi_im, potential, input ready);
    modport sink   (input valid, psi_re, psi_im, potential, output ready);
endinterface

// result channel
interface sss_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sss_pkg::PSI_W-1:0]     new_re;
    logic signed [sss_pkg::PSI_W-1:0]     new_im;
    logic                                 out_valid;
    logic                                 last_of_frame;

    modport source (output valid, new_re, new_im, out_valid, last_of_frame, input ready);
    modport sink   (input valid, new_re, new_im, out_valid, last_of_frame, output ready);
endinterface

// configuration write channel
interface sss_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [sss_pkg::REG_IDX_W-1:0]        index;
    logic [sss_pkg::CFG_W-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/schrodinger_stencil_step.sv =====
// top level of the schrodinger stencil step block
//
// Usage: cells of a complex wavefunction grid enter on i_cell in raster order,
// one request per cell with its potential. Every accepted cell gives exactly one
// result on o_res: the updated value of the cell one row plus one cell behind
// it, zero on the grid boundary, with out_valid low during the warm-up of the
// first row plus one cell after reset or a geometry write. last_of_frame marks
// the last interior cell of a grid.
// i_cfg writes grid_width, grid_height, lap_gain and time_step; it is always
// ready. The user must write it only while the pipeline is empty; the block
// does not enforce this. A geometry write restarts the frame at row 0, column 0.
// Throughput: one cell per cycle while o_res is not stalled. A result passes
// five register stages, the first loaded at the accepting edge (line buffer
// read, laplacian, gain and potential products, potential times psi products,
// sum and round).
// The line buffer is one memory read and written once per cell; the same
// column is touched again only w_eff cells later, after the write.
// Reset clears the counters, the pipeline valid bits and the configuration
// registers to their reset values; the line buffer is not cleared.
// When the receiver stalls, the output register holds; i_cell.ready follows
// o_res.ready through the stage chain in the same cycle, so with every stage
// full it falls at once, and only empty stages are filled before it falls.
module schrodinger_stencil_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sss_cell_if.sink    i_cell,
    sss_res_if.source   o_res,
    sss_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [sss_pkg::GW_W-1:0]   r_grid_width;
    logic [sss_pkg::GH_W-1:0]   r_grid_height;
    logic [sss_pkg::GAIN_W-1:0] r_lap_gain;
    logic [sss_pkg::GAIN_W-1:0] r_time_step;

    // raster position and warm-up
    logic [sss_pkg::COL_W-1:0]  r_col, n_col;
    logic [sss_pkg::GH_W-1:0]   r_row, n_row;
    logic [sss_pkg::FILL_W-1:0] r_fill, n_fill;

    logic [sss_pkg::GW_W-1:0]   w_eff;
    logic [sss_pkg::GW_W-1:0]   w_plus1;
    logic [sss_pkg::GH_W-1:0]   h_eff;
    logic                       col_last;
    logic                       row_last;
    logic                       cfg_acc;
    logic                       geo_write;
    logic                       in_acc;
    sss_pkg::t_flags            s0_flags;

    // pipeline handshakes
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic s1_move, s2_move, s3_move, s4_move;
    logic s1_free, s2_free, s3_free, s4_free, so_free;

    // line buffer memory
    sss_pkg::t_line             mem [sss_pkg::MAX_WIDTH];
    sss_pkg::t_line             r_rd;

    // stage 1 payload
    logic [sss_pkg::COL_W-1:0]        r1_col;
    sss_pkg::t_cell                   r1_cur;
    logic signed [sss_pkg::POT_W-1:0] r1_pin;
    sss_pkg::t_flags                  r1_flags;

    // window and holds
    sss_pkg::t_cell                   r_win1, r_win2;
    sss_pkg::t_cell                   r_north, r_south;
    logic signed [sss_pkg::POT_W-1:0] r_pot;

    logic signed [sss_pkg::LAP_W-1:0] lre, lim;

    // stage 2 payload
    sss_pkg::t_flags                  r2_flags;
    logic signed [sss_pkg::PSI_W-1:0] r2_cre, r2_cim;
    logic signed [sss_pkg::LAP_W-1:0] r2_lre, r2_lim;
    logic signed [sss_pkg::POT_W-1:0] r2_pot;

    // stage 3 payload
    sss_pkg::t_flags                  r3_flags;
    logic signed [sss_pkg::PSI_W-1:0] r3_cre, r3_cim;
    logic signed [sss_pkg::GPR_W-1:0] r3_glre, r3_glim;
    logic signed [sss_pkg::TV_W-1:0]  r3_tv;

    // stage 4 payload
    sss_pkg::t_flags                  r4_flags;
    logic signed [sss_pkg::PSI_W-1:0] r4_cre, r4_cim;
    logic signed [sss_pkg::GPR_W-1:0] r4_glre, r4_glim;
    logic signed [sss_pkg::TVC_W-1:0] r4_tvre, r4_tvim;

    // output register
    logic signed [sss_pkg::PSI_W-1:0] r_new_re, r_new_im;
    logic                             r_out_valid, r_last;

    logic signed [sss_pkg::ACC_W-1:0] acc_re, acc_im;

    // round to nearest with ties up, then saturate to psi width
    function automatic logic signed [sss_pkg::PSI_W-1:0] round_sat(
        input logic signed [sss_pkg::ACC_W-1:0] acc
    );
        logic signed [sss_pkg::ACC_W-1:0]                 y;
        logic signed [sss_pkg::ACC_W-sss_pkg::FRAC_SH-1:0] q;
        logic signed [sss_pkg::PSI_W-1:0]                 res;
        y = acc + (sss_pkg::ACC_W'(1) <<< (sss_pkg::FRAC_SH - 1));
        q = (sss_pkg::ACC_W-sss_pkg::FRAC_SH)'(y >>> sss_pkg::FRAC_SH);
        if (q > (sss_pkg::ACC_W-sss_pkg::FRAC_SH)'(32767)) begin
            res = 16'sh7fff;
        end else if (q < -(sss_pkg::ACC_W-sss_pkg::FRAC_SH)'(32768)) begin
            res = -16'sh8000;
        end else begin
            res = sss_pkg::PSI_W'(q);
        end
        return res;
    endfunction

    // effective geometry
    always_comb begin
        if (r_grid_width < sss_pkg::GW_W'(sss_pkg::MIN_DIM)) begin
            w_eff = sss_pkg::GW_W'(sss_pkg::MIN_DIM);
        end else if (r_grid_width > sss_pkg::GW_W'(sss_pkg::MAX_WIDTH)) begin
            w_eff = sss_pkg::GW_W'(sss_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_grid_width;
        end
        if (r_grid_height < sss_pkg::GH_W'(sss_pkg::MIN_DIM)) begin
            h_eff = sss_pkg::GH_W'(sss_pkg::MIN_DIM);
        end else begin
            h_eff = r_grid_height;
        end
        w_plus1 = w_eff + sss_pkg::GW_W'(1);
    end

    // handshake chain from the output register back to the input
    assign so_free = !r_vo || o_res.ready;
    assign s4_move = r_v4 && so_free;
    assign s4_free = !r_v4 || s4_move;
    assign s3_move = r_v3 && s4_free;
    assign s3_free = !r_v3 || s3_move;
    assign s2_move = r_v2 && s3_free;
    assign s2_free = !r_v2 || s2_move;
    assign s1_move = r_v1 && s2_free;
    assign s1_free = !r_v1 || s1_move;

    assign i_cell.ready = s1_free;
    assign in_acc       = i_cell.valid && s1_free;
    assign i_cfg.ready  = 1'b1;
    assign cfg_acc      = i_cfg.valid;

    // geometry writes restart the frame
    always_comb begin
        geo_write = 1'b0;
        if (cfg_acc) begin
            unique case (sss_pkg::t_reg_idx'(i_cfg.index))
                sss_pkg::REG_GRID_WIDTH, sss_pkg::REG_GRID_HEIGHT: geo_write = 1'b1;
                default: geo_write = 1'b0;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= sss_pkg::GRID_WIDTH_RST;
            r_grid_height <= sss_pkg::GRID_HEIGHT_RST;
            r_lap_gain    <= sss_pkg::LAP_GAIN_RST;
            r_time_step   <= sss_pkg::TIME_STEP_RST;
        end else if (cfg_acc) begin
            unique case (sss_pkg::t_reg_idx'(i_cfg.index))
                sss_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg.data[sss_pkg::GW_W-1:0];
                sss_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg.data[sss_pkg::GH_W-1:0];
                sss_pkg::REG_LAP_GAIN:    r_lap_gain    <= i_cfg.data[sss_pkg::GAIN_W-1:0];
                sss_pkg::REG_TIME_STEP:   r_time_step   <= i_cfg.data[sss_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position, warm-up and boundary classification of the request
    always_comb begin
        col_last = (sss_pkg::GW_W'(r_col) == (w_eff - sss_pkg::GW_W'(1)));
        row_last = (r_row == (h_eff - sss_pkg::GH_W'(1)));

        s0_flags.valid    = (r_fill >= w_plus1);
        s0_flags.interior = s0_flags.valid && (r_col >= sss_pkg::COL_W'(2))
                            && (r_row >= sss_pkg::GH_W'(2));
        s0_flags.last     = s0_flags.interior && col_last && row_last;

        n_col  = r_col;
        n_row  = r_row;
        n_fill = r_fill;
        if (geo_write) begin
            n_col  = '0;
            n_row  = '0;
            n_fill = '0;
        end else if (in_acc) begin
            if (r_fill < w_plus1) begin
                n_fill = r_fill + sss_pkg::FILL_W'(1);
            end
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + sss_pkg::GH_W'(1);
            end else begin
                n_col = r_col + sss_pkg::COL_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_vo   <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_fill <= n_fill;
            if (s1_free) r_v1 <= in_acc;
            if (s2_free) r_v2 <= s1_move;
            if (s3_free) r_v3 <= s2_move;
            if (s4_free) r_v4 <= s3_move;
            if (so_free) r_vo <= s4_move;
        end
    end

    // line buffer: read at accept, write back when the request leaves stage 1
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            mem[r1_col] <= '{pot: r1_pin, center: r1_cur, above: r_rd.center};
        end
        if (in_acc) begin
            r_rd <= mem[r_col];
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_col    <= r_col;
            r1_cur.re <= i_cell.psi_re;
            r1_cur.im <= i_cell.psi_im;
            r1_pin    <= i_cell.potential;
            r1_flags  <= s0_flags;
        end
    end

    // five-point laplacian on the shifted window and the holds
    always_comb begin
        lre = sss_pkg::LAP_W'(r_win1.re) + sss_pkg::LAP_W'(r_rd.center.re)
            + sss_pkg::LAP_W'(r_north.re) + sss_pkg::LAP_W'(r_south.re)
            - (sss_pkg::LAP_W'(r_win2.re) <<< 2);
        lim = sss_pkg::LAP_W'(r_win1.im) + sss_pkg::LAP_W'(r_rd.center.im)
            + sss_pkg::LAP_W'(r_north.im) + sss_pkg::LAP_W'(r_south.im)
            - (sss_pkg::LAP_W'(r_win2.im) <<< 2);
    end

    // window shift, holds and stage 2
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_win1   <= r_win2;
            r_win2   <= r_rd.center;
            r_north  <= r_rd.above;
            r_south  <= r1_cur;
            r_pot    <= r_rd.pot;
            r2_flags <= r1_flags;
            r2_cre   <= r_win2.re;
            r2_cim   <= r_win2.im;
            r2_lre   <= lre;
            r2_lim   <= lim;
            r2_pot   <= r_pot;
        end
    end

    // gain times laplacian, time step times potential
    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r3_flags <= r2_flags;
            r3_cre   <= r2_cre;
            r3_cim   <= r2_cim;
            r3_glre  <= sss_pkg::GPR_W'($signed({1'b0, r_lap_gain}))
                        * sss_pkg::GPR_W'(r2_lre);
            r3_glim  <= sss_pkg::GPR_W'($signed({1'b0, r_lap_gain}))
                        * sss_pkg::GPR_W'(r2_lim);
            r3_tv    <= sss_pkg::TV_W'($signed({1'b0, r_time_step}))
                        * sss_pkg::TV_W'(r2_pot);
        end
    end

    // potential term times psi
    always_ff @(posedge i_clk) begin
        if (s3_move) begin
            r4_flags <= r3_flags;
            r4_cre   <= r3_cre;
            r4_cim   <= r3_cim;
            r4_glre  <= r3_glre;
            r4_glim  <= r3_glim;
            r4_tvre  <= sss_pkg::TVC_W'(r3_tv) * sss_pkg::TVC_W'(r3_cre);
            r4_tvim  <= sss_pkg::TVC_W'(r3_tv) * sss_pkg::TVC_W'(r3_cim);
        end
    end

    // accumulate at the common scale
    always_comb begin
        acc_re = (sss_pkg::ACC_W'(r4_cre) <<< sss_pkg::FRAC_SH)
               - (sss_pkg::ACC_W'(r4_glim) <<< sss_pkg::LAP_SH)
               + sss_pkg::ACC_W'(r4_tvim);
        acc_im = (sss_pkg::ACC_W'(r4_cim) <<< sss_pkg::FRAC_SH)
               + (sss_pkg::ACC_W'(r4_glre) <<< sss_pkg::LAP_SH)
               - sss_pkg::ACC_W'(r4_tvre);
    end

    // output register, boundary and warm-up cells give zero
    always_ff @(posedge i_clk) begin
        if (s4_move) begin
            r_out_valid <= r4_flags.valid;
            r_last      <= r4_flags.last;
            if (r4_flags.interior) begin
                r_new_re <= round_sat(acc_re);
                r_new_im <= round_sat(acc_im);
            end else begin
                r_new_re <= '0;
                r_new_im <= '0;
            end
        end
    end

    assign o_res.valid         = r_vo;
    assign o_res.new_re        = r_new_re;
    assign o_res.new_im        = r_new_im;
    assign o_res.out_valid     = r_out_valid;
    assign o_res.last_of_frame = r_last;

endmodule

// ===== rtl/core/sss_checker.sv =====
// port checker of the schrodinger stencil step block and its bind
module sss_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             i_ready,
    input logic signed [sss_pkg::PSI_W-1:0] i_new_re,
    input logic signed [sss_pkg::PSI_W-1:0] i_new_im,
    input logic                             i_out_valid,
    input logic                             i_last
);

    // end of frame only on a cell past the warm-up
    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_out_valid)
        else $error("last_of_frame set during warm-up");

    // warm-up results carry zeros
    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_out_valid |-> i_new_re == '0 && i_new_im == '0 && !i_last)
        else $error("warm-up result not zero");

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_new_re) && $stable(i_new_im)
            && $stable(i_out_valid) && $stable(i_last))
        else $error("result payload changed while stalled");

endmodule

bind schrodinger_stencil_step sss_checker u_sss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_new_re    (o_res.new_re),
    .i_new_im    (o_res.new_im),
    .i_out_valid (o_res.out_valid),
    .i_last      (o_res.last_of_frame)
);

// ===== tb/schrodinger_stencil_step_checker.sv =====
// result checker for the schrodinger stencil step block: shadow stencil, expected results, compare
`timescale 1ns / 1ps
module schrodinger_stencil_step_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sss_cell_if  i_cell,
    sss_res_if   i_res,
    sss_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import sss_pkg::*;

    localparam int     PRINT_CAP = 100;
    localparam longint PSI_MAX   = 32767;
    localparam longint PSI_MIN   = -32768;

    typedef struct packed {
        logic signed [PSI_W-1:0] new_re;
        logic signed [PSI_W-1:0] new_im;
        logic                    out_valid;
        logic                    last_of_frame;
    } t_cell_update;

    // shadow copy of the configuration registers
    logic [GW_W-1:0]   grid_width;
    logic [GH_W-1:0]   grid_height;
    logic [GAIN_W-1:0] lap_gain;
    logic [GAIN_W-1:0] time_step;

    // shadow line buffers, three-cell window and one-cell holds
    t_cell                   above_row  [MAX_WIDTH];
    t_cell                   center_row [MAX_WIDTH];
    logic signed [POT_W-1:0] pot_row    [MAX_WIDTH];
    t_cell                   win        [3];
    t_cell                   north_cell;
    t_cell                   south_cell;
    logic signed [POT_W-1:0] pot_cell;
    int                      col_pos;
    int                      row_pos;
    int                      fill_level;

    t_cell_update expected_updates[$];
    int           fails;
    int           update_count;

    function automatic int eff_width();
        if (grid_width < MIN_DIM) return MIN_DIM;
        if (grid_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(grid_width);
    endfunction

    function automatic int eff_height();
        if (grid_height < MIN_DIM) return MIN_DIM;
        return int'(grid_height);
    endfunction

    function automatic longint wide(logic signed [PSI_W-1:0] v);
        return v;
    endfunction

    // round to nearest with ties up, then clip to the psi range
    function automatic logic signed [PSI_W-1:0] round_to_psi(longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
        if (q > PSI_MAX) q = PSI_MAX;
        if (q < PSI_MIN) q = PSI_MIN;
        return PSI_W'(q);
    endfunction

    task automatic restart_frame();
        col_pos    = 0;
        row_pos    = 0;
        fill_level = 0;
    endtask

    task automatic reset_shadow();
        grid_width  = GRID_WIDTH_RST;
        grid_height = GRID_HEIGHT_RST;
        lap_gain    = LAP_GAIN_RST;
        time_step   = TIME_STEP_RST;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            above_row[i]  = '0;
            center_row[i] = '0;
            pot_row[i]    = '0;
        end
        for (int i = 0; i < 3; i++) win[i] = '0;
        north_cell = '0;
        south_cell = '0;
        pot_cell   = '0;
        restart_frame();
    endtask

    task automatic apply_reg_write(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        case (idx)
            REG_GRID_WIDTH: begin
                grid_width = value[GW_W-1:0];
                restart_frame();
            end
            REG_GRID_HEIGHT: begin
                grid_height = value[GH_W-1:0];
                restart_frame();
            end
            REG_LAP_GAIN:  lap_gain  = value[GAIN_W-1:0];
            REG_TIME_STEP: time_step = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // push one cell through the shadow stencil, return the cell one row plus one behind
    function automatic t_cell_update advance_stencil(t_cell cur, logic signed [POT_W-1:0] pin);
        int                      w;
        int                      h;
        int                      qr;
        int                      qc;
        t_cell                   above;
        t_cell                   mid;
        logic signed [POT_W-1:0] pv;
        logic                    warm;
        longint                  cre;
        longint                  cim;
        longint                  lre;
        longint                  lim;
        longint                  g;
        longint                  tv;
        t_cell_update            upd;
        w     = eff_width();
        h     = eff_height();
        above = above_row[col_pos];
        mid   = center_row[col_pos];
        pv    = pot_row[col_pos];
        warm  = (fill_level >= w + 1);

        above_row[col_pos]  = mid;
        center_row[col_pos] = cur;
        pot_row[col_pos]    = pin;
        win[0] = win[1];
        win[1] = win[2];
        win[2] = mid;

        // position of the cell that leaves now
        if (col_pos >= 1) begin
            qr = row_pos - 1;
            qc = col_pos - 1;
        end else begin
            qr = row_pos - 2;
            qc = w - 1;
        end

        upd           = '0;
        upd.out_valid = warm;
        if (warm && qr >= 1 && qr <= h - 2 && qc >= 1 && qc <= w - 2) begin
            cre = wide(win[1].re);
            cim = wide(win[1].im);
            lre = wide(win[0].re) + wide(win[2].re) + wide(north_cell.re)
                + wide(south_cell.re) - 4 * cre;
            lim = wide(win[0].im) + wide(win[2].im) + wide(north_cell.im)
                + wide(south_cell.im) - 4 * cim;
            g   = longint'(lap_gain);
            tv  = longint'(time_step) * wide(pot_cell);
            upd.new_re = round_to_psi((cre <<< FRAC_SH) - ((g * lim) <<< LAP_SH) + tv * cim);
            upd.new_im = round_to_psi((cim <<< FRAC_SH) + ((g * lre) <<< LAP_SH) - tv * cre);
            upd.last_of_frame = (qr == h - 2 && qc == w - 2);
        end

        north_cell = above;
        south_cell = cur;
        pot_cell   = pv;

        // raster position and warm-up count
        if (fill_level < w + 1) fill_level++;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return upd;
    endfunction

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= PRINT_CAP)
            $display("[%0t] result %0d: %s", $realtime, update_count, msg);
    endtask

    initial begin
        fails        = 0;
        update_count = 0;
    end

    // watch the three channels at each edge
    always @(posedge i_clk) begin : watch
        t_cell_update want;
        t_cell        cur;
        if (!i_rst_n) begin
            reset_shadow();
            expected_updates.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                apply_reg_write(t_reg_idx'(i_cfg.index), i_cfg.data);

            // result request: compare with the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (expected_updates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result re %0d im %0d",
                                              i_res.new_re, i_res.new_im));
                end else begin
                    want = expected_updates.pop_front();
                    if (i_res.new_re !== want.new_re)
                        report_mismatch($sformatf("new_re got %0d expected %0d",
                                                  i_res.new_re, want.new_re));
                    if (i_res.new_im !== want.new_im)
                        report_mismatch($sformatf("new_im got %0d expected %0d",
                                                  i_res.new_im, want.new_im));
                    if (i_res.out_valid !== want.out_valid)
                        report_mismatch($sformatf("out_valid got %b expected %b",
                                                  i_res.out_valid, want.out_valid));
                    if (i_res.last_of_frame !== want.last_of_frame)
                        report_mismatch($sformatf("last_of_frame got %b expected %b",
                                                  i_res.last_of_frame, want.last_of_frame));
                end
                update_count++;
            end

            // cell request: predict its result
            if (i_cell.valid && i_cell.ready) begin
                cur.re = i_cell.psi_re;
                cur.im = i_cell.psi_im;
                expected_updates.push_back(advance_stencil(cur, i_cell.potential));
            end
        end
        o_pending    <= expected_updates.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/schrodinger_stencil_step_tb.sv =====
// testbench top for the schrodinger stencil step block: stimulus, flow control and verdict
`timescale 1ns / 1ps
module schrodinger_stencil_step_tb;
    import sss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_CELLS = 620;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_SETTLE  = 8;
    localparam int PHASE_CAP    = 300;

    logic i_clk;
    logic i_rst_n;

    sss_cell_if cell_ch ();
    sss_res_if  res_ch ();
    sss_cfg_if  cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count;
    int cells_sent;
    int reg_writes;
    int phase_count;
    int random_cells;
    int cur_w;
    int cur_h;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_stall_left;

    schrodinger_stencil_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    schrodinger_stencil_step_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell       (cell_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("schrodinger_stencil_step_tb failed");
        $finish;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // psi or potential sample: extremes, small values or anything
    function automatic logic [15:0] pick_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 60) begin
            v = int'($urandom_range(0, 8191)) - 4096;
            return v[15:0];
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (r < 60) return 16'($urandom_range(0, 1024));
        return 16'($urandom);
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // result side: ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall_left = 0;
            res_ch.ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall_left = idle_length() - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // one register write request; the caller lowers valid after the last one
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic configure(input logic [3:0] mask, input logic [CFG_W-1:0] width_word,
                             input logic [CFG_W-1:0] height_word,
                             input logic [CFG_W-1:0] gain_word,
                             input logic [CFG_W-1:0] step_word);
        if (mask[REG_GRID_WIDTH]) begin
            write_reg(REG_GRID_WIDTH, width_word);
            cur_w = clamp_dim(int'(width_word[GW_W-1:0]), MAX_WIDTH);
        end
        if (mask[REG_GRID_HEIGHT]) begin
            write_reg(REG_GRID_HEIGHT, height_word);
            cur_h = clamp_dim(int'(height_word), 65535);
        end
        if (mask[REG_LAP_GAIN])  write_reg(REG_LAP_GAIN, gain_word);
        if (mask[REG_TIME_STEP]) write_reg(REG_TIME_STEP, step_word);
        cfg_ch.valid <= 1'b0;
    endtask

    // one cell request, then maybe an idle gap
    task automatic send_cell(input logic [15:0] re, input logic [15:0] im,
                             input logic [15:0] pot);
        int gap;
        cell_ch.valid     <= 1'b1;
        cell_ch.psi_re    <= re;
        cell_ch.psi_im    <= im;
        cell_ch.potential <= pot;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        cells_sent++;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_length() : 0;
        if (gap > 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_cells(input int n);
        for (int i = 0; i < n; i++) send_cell(pick_sample(), pick_sample(), pick_sample());
        cell_ch.valid <= 1'b0;
    endtask

    // all results back, pipeline empty
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] extremes [4];
        logic [3:0]  mask;
        int          w;
        int          h;
        int          n;
        int          r;
        extremes = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

        i_rst_n           <= 1'b0;
        cell_ch.valid     <= 1'b0;
        cell_ch.psi_re    <= '0;
        cell_ch.psi_im    <= '0;
        cell_ch.potential <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_GRID_WIDTH;
        cfg_ch.data       <= '0;
        tx_idle_pct   <= 0;
        rx_idle_pct   <= 0;
        cells_sent    = 0;
        reg_writes    = 0;
        phase_count   = 0;
        random_cells  = 0;
        cur_w         = 1024;
        cur_h         = 1024;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry and gains: warm-up results only
        for (int i = 0; i < 6; i++)
            send_cell(extremes[i % 4], extremes[(i + 1) % 4], extremes[(i + 2) % 4]);
        cell_ch.valid <= 1'b0;
        wait_drained();
        phase_count++;

        // smallest grid, full gains, extreme cells through a frame and its tail
        configure(4'hF, 16'd3, 16'd3, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 13; i++)
            send_cell(extremes[$urandom_range(0, 3)], extremes[$urandom_range(0, 3)],
                      extremes[$urandom_range(0, 3)]);
        cell_ch.valid <= 1'b0;
        wait_drained();
        phase_count++;

        // width below range, tallest grid
        tx_idle_pct <= 20;
        rx_idle_pct <= 20;
        configure(4'hF, 16'hF800, 16'hFFFF, 16'd1, 16'h8000);
        send_random_cells(9);
        wait_drained();
        phase_count++;

        // widest grid (width field above range), height below range, warm-up stretch
        tx_idle_pct <= 0;
        rx_idle_pct <= 5;
        configure(4'hF, 16'hFFFF, 16'h0000, pick_gain(), pick_gain());
        send_random_cells(PHASE_CAP);
        wait_drained();
        phase_count++;

        // random phases: mostly whole frames with random content
        while (random_cells < RANDOM_CELLS) begin
            mask = 4'($urandom_range(1, 15));
            r = $urandom_range(0, 99);
            if (r < 70)      w = $urandom_range(3, 10);
            else if (r < 80) w = $urandom_range(0, 2);
            else             w = $urandom_range(11, 40);
            r = $urandom_range(0, 99);
            if (r < 70)      h = $urandom_range(3, 8);
            else if (r < 85) h = $urandom_range(0, 2);
            else             h = $urandom_range(9, 20);
            if ($urandom_range(0, 3) == 0) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end else begin
                tx_idle_pct <= $urandom_range(5, 40);
                rx_idle_pct <= $urandom_range(5, 40);
            end
            configure(mask, {5'($urandom), 11'(w)}, 16'(h), pick_gain(), pick_gain());
            n = $urandom_range(1, 2) * cur_w * cur_h + $urandom_range(0, cur_w + 1);
            if (n > PHASE_CAP) n = PHASE_CAP;
            if (n > RANDOM_CELLS - random_cells) n = RANDOM_CELLS - random_cells;
            send_random_cells(n);
            random_cells += n;
            wait_drained();
            phase_count++;
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d cells and %0d register writes over %0d phases",
                 cells_sent, reg_writes, phase_count);
        $display("grids from 3x3 to 1024 wide, clamped geometry, gaps and stalls on both sides");
        if (fail_count == 0) begin
            $display("schrodinger_stencil_step_tb passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("schrodinger_stencil_step_tb failed");
        end
        $finish;
    end

endmodule
